// ===== design/imb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imb_pkg
// Shared widths, operation and status codes, and the memory control bundle
// of the indexed message buffer.
// ----------------------------------------------------------------------------
package imb_pkg;

  localparam int IMB_DEPTH = 256;

  localparam int OP_W   = 4;
  localparam int WORD_W = 16;
  localparam int IDX_W  = 9;
  localparam int ST_W   = 3;

  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;

  localparam logic [OP_W-1:0] OP_CLEAR      = 4'd0;
  localparam logic [OP_W-1:0] OP_GET        = 4'd1;
  localparam logic [OP_W-1:0] OP_PUT        = 4'd2;
  localparam logic [OP_W-1:0] OP_GET_AT     = 4'd3;
  localparam logic [OP_W-1:0] OP_PUT_AT     = 4'd4;
  localparam logic [OP_W-1:0] OP_PUT_UNIQUE = 4'd5;
  localparam logic [OP_W-1:0] OP_POP        = 4'd6;
  localparam logic [OP_W-1:0] OP_SET_RD     = 4'd7;
  localparam logic [OP_W-1:0] OP_SET_WR     = 4'd8;

  localparam logic [ST_W-1:0] ST_OK      = 3'd0;
  localparam logic [ST_W-1:0] ST_PRESENT = 3'd1;
  localparam logic [ST_W-1:0] ST_FULL    = 3'd2;
  localparam logic [ST_W-1:0] ST_EMPTY   = 3'd3;
  localparam logic [ST_W-1:0] ST_OUT_BUF = 3'd4;
  localparam logic [ST_W-1:0] ST_OUT_MSG = 3'd5;

  // Register index, taken from the word address.
  localparam logic REG_MAX_LEN = 1'b0;
  localparam logic [IDX_W-1:0] MAX_LEN_RESET = 9'd256;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } mem_ctl_t;

endpackage

// ===== design/imb_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imb_in_if / imb_out_if
// Valid/ready channels for operation beats and result beats.
// ----------------------------------------------------------------------------
interface imb_in_if;
  logic              valid;
  logic              ready;
  logic [3:0]        opcode;
  logic [15:0]       data_value;
  logic signed [8:0] position;

  modport source (output valid, opcode, data_value, position, input ready);
  modport sink (input valid, opcode, data_value, position, output ready);
endinterface

interface imb_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [15:0] read_data;
  logic [8:0]  message_length;
  logic [8:0]  read_index;
  logic [8:0]  write_index;

  modport source (output valid, status, read_data, message_length, read_index,
                  write_index, input ready);
  modport sink (input valid, status, read_data, message_length, read_index,
                write_index, output ready);
endinterface

// ===== design/imb_cfg_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imb_cfg_regs
// APB register slice holding max_len; derives the capacity in use.
// ----------------------------------------------------------------------------
module imb_cfg_regs #(
  parameter int DEPTH = imb_pkg::IMB_DEPTH
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [imb_pkg::CFG_AW-1:0]  paddr,
  input  logic [imb_pkg::CFG_DW-1:0]  pwdata,
  output logic [imb_pkg::CFG_DW-1:0]  prdata,
  output logic                        pready,
  output logic [imb_pkg::IDX_W-1:0]   cap
);
  import imb_pkg::*;

  localparam logic [IDX_W-1:0] DEPTH_W = IDX_W'(DEPTH);

  logic [IDX_W-1:0] max_len_r;
  logic [IDX_W-1:0] max_len_nxt;
  logic             hit;

  assign hit    = (paddr[2] == REG_MAX_LEN);
  assign pready = 1'b1;
  assign prdata = hit ? {{(CFG_DW-IDX_W){1'b0}}, max_len_r} : '0;
  assign cap    = (max_len_r < DEPTH_W) ? max_len_r : DEPTH_W;

  always_comb begin
    max_len_nxt = max_len_r;
    if (psel && penable && pwrite && hit) begin
      max_len_nxt = pwdata[IDX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= MAX_LEN_RESET;
    end else begin
      max_len_r <= max_len_nxt;
    end
  end

endmodule

// ===== design/imb_store.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imb_store
// Word memory with one write and one registered read port. Per-entry valid
// bits make never-written words read as zero after reset.
// ----------------------------------------------------------------------------
module imb_store #(
  parameter int DEPTH = imb_pkg::IMB_DEPTH,
  parameter int AW    = $clog2(imb_pkg::IMB_DEPTH)
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  imb_pkg::mem_ctl_t           ctl,
  input  logic [AW-1:0]               rd_addr,
  input  logic [AW-1:0]               wr_addr,
  input  logic [imb_pkg::WORD_W-1:0]  wr_data,
  output logic [imb_pkg::WORD_W-1:0]  rd_data
);
  import imb_pkg::*;

  logic [WORD_W-1:0] mem_r [DEPTH];
  logic [DEPTH-1:0]  valid_r;
  logic [WORD_W-1:0] q_r;
  logic              qv_r;

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (ctl.rd_en) begin
      q_r  <= mem_r[rd_addr];
      qv_r <= valid_r[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (ctl.wr_en) begin
      valid_r[wr_addr] <= 1'b1;
    end
  end

  assign rd_data = qv_r ? q_r : '0;

endmodule

// ===== design/imb_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imb_ctrl
// Operation sequencer: issues the word read at accept, scans the message for
// put_unique, then updates indices, writes the word and loads the result.
// ----------------------------------------------------------------------------
module imb_ctrl #(
  parameter int DEPTH = imb_pkg::IMB_DEPTH,
  parameter int AW    = $clog2(imb_pkg::IMB_DEPTH)
) (
  input  logic                        clk,
  input  logic                        rst_n,
  imb_in_if.sink                      in_ch,
  imb_out_if.source                   out_ch,
  input  logic [imb_pkg::IDX_W-1:0]   cap,
  output imb_pkg::mem_ctl_t           mem_ctl,
  output logic [AW-1:0]               mem_rd_addr,
  output logic [AW-1:0]               mem_wr_addr,
  output logic [imb_pkg::WORD_W-1:0]  mem_wr_data,
  input  logic [imb_pkg::WORD_W-1:0]  mem_rd_data
);
  import imb_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_EXEC = 2'd2;

  localparam logic [IDX_W-1:0] DEPTH_W = IDX_W'(DEPTH);

  logic [1:0]        state_r, state_nxt;
  logic [OP_W-1:0]   op_r, op_nxt;
  logic [WORD_W-1:0] dv_r, dv_nxt;
  logic [IDX_W-1:0]  pos_r, pos_nxt;
  logic [IDX_W-1:0]  rp_r, rp_nxt;
  logic [IDX_W-1:0]  wp_r, wp_nxt;
  logic [IDX_W-1:0]  ml_r, ml_nxt;
  logic [IDX_W-1:0]  scan_r, scan_nxt;
  logic              found_r, found_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [ST_W-1:0]   status_r, status_nxt;
  logic [WORD_W-1:0] rdata_r, rdata_nxt;

  logic              in_fire;
  logic              out_free;
  logic [IDX_W-1:0]  in_pos;
  logic [IDX_W-1:0]  scan_inc;
  logic [IDX_W-1:0]  wp_inc;
  logic [IDX_W-1:0]  pos_inc;
  logic [IDX_W-1:0]  ml_dec;
  logic              full;
  logic [IDX_W:0]    t_rd;
  logic [IDX_W:0]    t_wr;

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;
  assign in_pos      = IDX_W'($unsigned(in_ch.position));

  assign scan_inc = scan_r + 9'd1;
  assign wp_inc   = wp_r + 9'd1;
  assign pos_inc  = pos_r + 9'd1;
  assign ml_dec   = ml_r - 9'd1;
  // Append is refused one word short of capacity, or with the write index at the end.
  assign full     = (({1'b0, ml_r} + 10'd1) == {1'b0, cap}) || (wp_r >= cap)
                    || (wp_r >= DEPTH_W);
  // Offsets from the message end; bit IDX_W is the sign of the sum.
  assign t_rd     = {1'b0, ml_r} + {pos_r[IDX_W-1], pos_r};
  assign t_wr     = t_rd + 10'd1;

  assign out_ch.valid          = out_valid_r;
  assign out_ch.status         = status_r;
  assign out_ch.read_data      = rdata_r;
  assign out_ch.message_length = ml_r;
  assign out_ch.read_index     = rp_r;
  assign out_ch.write_index    = wp_r;

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    dv_nxt        = dv_r;
    pos_nxt       = pos_r;
    rp_nxt        = rp_r;
    wp_nxt        = wp_r;
    ml_nxt        = ml_r;
    scan_nxt      = scan_r;
    found_nxt     = found_r;
    status_nxt    = status_r;
    rdata_nxt     = rdata_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    mem_ctl       = '0;
    mem_rd_addr   = '0;
    mem_wr_addr   = '0;
    mem_wr_data   = dv_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          op_nxt      = in_ch.opcode;
          dv_nxt      = in_ch.data_value;
          pos_nxt     = in_pos;
          scan_nxt    = '0;
          found_nxt   = 1'b0;
          mem_ctl.rd_en = 1'b1;
          case (in_ch.opcode)
            OP_GET:    mem_rd_addr = rp_r[AW-1:0];
            OP_GET_AT: mem_rd_addr = in_pos[AW-1:0];
            OP_POP:    mem_rd_addr = ml_dec[AW-1:0];
            default:   mem_rd_addr = '0;
          endcase
          if (in_ch.opcode == OP_PUT_UNIQUE && ml_r != '0) begin
            state_nxt = S_SCAN;
          end else begin
            state_nxt = S_EXEC;
          end
        end
      end

      S_SCAN: begin
        // Word scan_r is on the read port; the next one is fetched meanwhile.
        if (mem_rd_data == dv_r) begin
          found_nxt = 1'b1;
          state_nxt = S_EXEC;
        end else if (scan_inc >= ml_r) begin
          state_nxt = S_EXEC;
        end else begin
          scan_nxt      = scan_inc;
          mem_ctl.rd_en = 1'b1;
          mem_rd_addr   = scan_inc[AW-1:0];
        end
      end

      S_EXEC: begin
        if (out_free) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
          status_nxt    = ST_OK;
          rdata_nxt     = '0;
          case (op_r) inside
            OP_CLEAR: begin
              rp_nxt = '0;
              wp_nxt = '0;
              ml_nxt = '0;
            end
            OP_GET: begin
              if (rp_r >= ml_r || rp_r >= DEPTH_W) begin
                status_nxt = ST_EMPTY;
              end else begin
                rdata_nxt = mem_rd_data;
                rp_nxt    = rp_r + 9'd1;
              end
            end
            OP_PUT, OP_PUT_UNIQUE: begin
              if (op_r == OP_PUT_UNIQUE && found_r) begin
                status_nxt = ST_PRESENT;
              end else if (full) begin
                status_nxt = ST_FULL;
              end else begin
                mem_ctl.wr_en = 1'b1;
                mem_wr_addr   = wp_r[AW-1:0];
                wp_nxt        = wp_inc;
                ml_nxt        = (wp_inc > ml_r) ? wp_inc : ml_r;
              end
            end
            OP_GET_AT: begin
              if (pos_r >= cap) begin
                status_nxt = ST_OUT_BUF;
              end else if (pos_r >= ml_r) begin
                status_nxt = ST_OUT_MSG;
              end else begin
                rdata_nxt = mem_rd_data;
                rp_nxt    = pos_inc;
              end
            end
            OP_PUT_AT: begin
              if (pos_r >= cap) begin
                status_nxt = ST_OUT_BUF;
              end else begin
                mem_ctl.wr_en = 1'b1;
                mem_wr_addr   = pos_r[AW-1:0];
                wp_nxt        = pos_inc;
                ml_nxt        = (pos_inc > ml_r) ? pos_inc : ml_r;
              end
            end
            OP_POP: begin
              if (ml_r == '0) begin
                status_nxt = ST_EMPTY;
              end else begin
                ml_nxt    = ml_dec;
                rdata_nxt = mem_rd_data;
                wp_nxt    = (wp_r > ml_dec) ? ml_dec : wp_r;
              end
            end
            OP_SET_RD: begin
              if (!pos_r[IDX_W-1]) begin
                if (pos_r >= cap) begin
                  status_nxt = ST_OUT_BUF;
                end else begin
                  rp_nxt = pos_r;
                  if (pos_r >= ml_r) begin
                    status_nxt = ST_OUT_MSG;
                  end
                end
              end else if (t_rd[IDX_W]) begin
                status_nxt = ST_OUT_BUF;
              end else begin
                rp_nxt = t_rd[IDX_W-1:0];
              end
            end
            OP_SET_WR: begin
              if (!pos_r[IDX_W-1]) begin
                if (pos_r >= cap) begin
                  status_nxt = ST_OUT_BUF;
                end else begin
                  wp_nxt = pos_r;
                end
              end else if (t_wr[IDX_W]) begin
                status_nxt = ST_OUT_BUF;
              end else begin
                wp_nxt = t_wr[IDX_W-1:0];
              end
            end
            default: begin
            end
          endcase
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      rp_r        <= '0;
      wp_r        <= '0;
      ml_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rp_r        <= rp_nxt;
      wp_r        <= wp_nxt;
      ml_r        <= ml_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r     <= op_nxt;
    dv_r     <= dv_nxt;
    pos_r    <= pos_nxt;
    scan_r   <= scan_nxt;
    found_r  <= found_nxt;
    status_r <= status_nxt;
    rdata_r  <= rdata_nxt;
  end

endmodule

// ===== design/indexed_message_buffer_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed_message_buffer_core
// Word message store with read index, write index and length, one result
// beat per operation beat, and an APB capacity register.
// ----------------------------------------------------------------------------
// Each operation has an accept step, which issues the one read of the word
// memory, and an execute step, which loads the result register. put_unique
// scans between the two (not on an empty message), reading one stored word
// per cycle through the memory's single read port and stopping at the first
// match. One operation is in flight at a time; a new beat is taken while the
// previous result still waits in the output register, and the execute step
// is held until that result is taken.
// The store reads as zero after reset through per-word valid bits, so there
// is no clearing pass. max_len sits at byte address 0 and may only be written
// while idle.
module indexed_message_buffer_core #(
  parameter int DEPTH = imb_pkg::IMB_DEPTH
) (
  input  logic                        clk,
  input  logic                        rst_n,
  imb_in_if.sink                      in_ch,
  imb_out_if.source                   out_ch,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [imb_pkg::CFG_AW-1:0]  cfg_paddr,
  input  logic [imb_pkg::CFG_DW-1:0]  cfg_pwdata,
  output logic [imb_pkg::CFG_DW-1:0]  cfg_prdata,
  output logic                        cfg_pready
);
  import imb_pkg::*;

  localparam int AW = $clog2(DEPTH);

  logic [IDX_W-1:0]  cap;
  mem_ctl_t          mem_ctl;
  logic [AW-1:0]     mem_rd_addr;
  logic [AW-1:0]     mem_wr_addr;
  logic [WORD_W-1:0] mem_wr_data;
  logic [WORD_W-1:0] mem_rd_data;

  imb_cfg_regs #(.DEPTH(DEPTH)) u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cap     (cap)
  );

  imb_store #(.DEPTH(DEPTH), .AW(AW)) u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (mem_ctl),
    .rd_addr (mem_rd_addr),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_data (mem_rd_data)
  );

  imb_ctrl #(.DEPTH(DEPTH), .AW(AW)) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cap         (cap),
    .mem_ctl     (mem_ctl),
    .mem_rd_addr (mem_rd_addr),
    .mem_wr_addr (mem_wr_addr),
    .mem_wr_data (mem_wr_data),
    .mem_rd_data (mem_rd_data)
  );

endmodule

// ===== design/imb_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imb_checker
// Port-level checks on the result channel, bound to the core.
// ----------------------------------------------------------------------------
module imb_checker #(
  parameter int DEPTH = imb_pkg::IMB_DEPTH
) (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  status,
  input logic [15:0] read_data,
  input logic [8:0]  message_length,
  input logic [8:0]  read_index
);
  import imb_pkg::*;

  localparam logic [IDX_W-1:0] DEPTH_W = IDX_W'(DEPTH);

  // A result beat waits until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped before it was taken");

  a_rdata_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && status != ST_OK |-> read_data == '0)
    else $error("failed operation returned a nonzero word");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> status <= ST_OUT_MSG)
    else $error("status code out of range");

  a_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> message_length <= DEPTH_W && read_index <= DEPTH_W)
    else $error("index beyond the memory depth");

endmodule

bind indexed_message_buffer_core imb_checker #(.DEPTH(DEPTH)) u_imb_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .status         (out_ch.status),
  .read_data      (out_ch.read_data),
  .message_length (out_ch.message_length),
  .read_index     (out_ch.read_index)
);
